// ===== rtl/mps_pkg.sv =====
// Package for the maze path search block: transaction types, codes and the
// direction step tables. No dependencies.
`default_nettype none

package mps_pkg;

    // Default sizes handed to the top level parameters
    localparam int GRID_DIM_DEF    = 16;
    localparam int STACK_DEPTH_DEF = 62;

    // Grid size register reset value
    localparam logic [4:0] GRID_SIZE_RESET = 5'd10;

    // Configuration register indexes
    localparam logic [1:0] REG_GRID_ROWS = 2'd0;
    localparam logic [1:0] REG_GRID_COLS = 2'd1;

    // Input operations
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_START = 1'b1;

    // Result status codes
    localparam logic [1:0] STAT_PATH     = 2'd0;
    localparam logic [1:0] STAT_NO_PATH  = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;

    // Input transaction
    typedef struct packed {
        logic       op;
        logic [3:0] cell_row;
        logic [3:0] cell_col;
        logic       wall;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic [3:0] path_row;
        logic [3:0] path_col;
        logic [1:0] status;
        logic       last;
    } out_item_t;

    // Row step per direction, clockwise from north, two's complement
    function automatic logic [1:0] step_drow(input logic [2:0] dir);
        logic [1:0] d;
        unique case (dir)
            3'd0, 3'd1, 3'd7: d = 2'b11;
            3'd3, 3'd4, 3'd5: d = 2'b01;
            default:          d = 2'b00;
        endcase
        return d;
    endfunction

    // Column step per direction, clockwise from north, two's complement
    function automatic logic [1:0] step_dcol(input logic [2:0] dir);
        logic [1:0] d;
        unique case (dir)
            3'd1, 3'd2, 3'd3: d = 2'b01;
            3'd5, 3'd6, 3'd7: d = 2'b11;
            default:          d = 2'b00;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/maze_path_search_dfs.sv =====
// Maze path search, depth first with an explicit stack held in memory.
// A cell write is taken while idle. A start first sweeps the cell memory,
// then probes the neighbors of the current cell in turn, reading the cell
// word of each in-grid neighbor that is not the exit, and pops when all are
// tried; the path then leaves item by item, the stacked cells read from the stack memory port.
// Items are taken one at a time. Reset clears control and the grid size
// registers (10 x 10); the cell and stack memories are not reset.
// Depends on mps_pkg.
`default_nettype none

module maze_path_search_dfs
    import mps_pkg::*;
#(
    parameter int GRID_DIM    = GRID_DIM_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire in_item_t   item_data,

    output logic            result_valid,
    input  wire logic       result_stall,
    output out_item_t       result_data,

    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [4:0] cfg_data
);

    // Coordinate, address and stack widths
    localparam int CW    = $clog2(GRID_DIM);
    localparam int NW    = CW + 1;
    localparam int AW    = 2 * CW;
    localparam int CELLS = 1 << AW;
    localparam int TW    = $clog2(STACK_DEPTH + 1);
    localparam int SAW   = $clog2(STACK_DEPTH);

    // Sequencer states
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_CLEAR    = 4'd1;
    localparam logic [3:0] ST_PROBE    = 4'd2;
    localparam logic [3:0] ST_CHECK    = 4'd3;
    localparam logic [3:0] ST_POP      = 4'd4;
    localparam logic [3:0] ST_OUT_RD   = 4'd5;
    localparam logic [3:0] ST_OUT_LD   = 4'd6;
    localparam logic [3:0] ST_OUT_CUR  = 4'd7;
    localparam logic [3:0] ST_OUT_EXIT = 4'd8;
    localparam logic [3:0] ST_FAIL     = 4'd9;

    localparam logic [AW-1:0] START_ADDR = {CW'(1), CW'(1)};

    typedef struct packed {
        logic [CW-1:0] row;
        logic [CW-1:0] col;
        logic [3:0]    dir;
    } stack_entry_t;

    // Cell word: wall bit and visited bit
    typedef struct packed {
        logic wall;
        logic seen;
    } cell_word_t;

    // Memories
    cell_word_t   cell_mem [CELLS];
    stack_entry_t stack_mem [STACK_DEPTH];

    // Registers
    logic [3:0]    state_reg, state_next;
    logic [4:0]    grid_rows_reg, grid_cols_reg;
    logic [NW-1:0] rows_reg, rows_next;
    logic [NW-1:0] cols_reg, cols_next;
    logic [AW:0]   clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0] cur_row_reg, cur_row_next;
    logic [CW-1:0] cur_col_reg, cur_col_next;
    logic [3:0]    cur_dir_reg, cur_dir_next;
    logic [CW-1:0] nbr_row_reg, nbr_row_next;
    logic [CW-1:0] nbr_col_reg, nbr_col_next;
    logic [TW-1:0] top_reg, top_next;
    logic [TW-1:0] out_idx_reg, out_idx_next;
    logic [1:0]    fail_stat_reg, fail_stat_next;
    logic          result_valid_reg;
    out_item_t     result_data_reg;
    cell_word_t    cell_rdata_reg;
    stack_entry_t  stack_rdata_reg;

    // Memory port controls
    logic          cell_rd_en;
    logic [AW-1:0] cell_rd_addr;
    logic          cell_wr_en;
    logic [AW-1:0] cell_wr_addr;
    cell_word_t    cell_wr_data;
    logic          stack_rd_en;
    logic [SAW-1:0] stack_rd_addr;
    logic          stack_wr_en;
    stack_entry_t  stack_wr_data;

    // Output register controls
    logic          out_free;
    logic          out_load;
    out_item_t     out_item;

    // Neighbor arithmetic
    logic [1:0]    drow, dcol;
    logic [NW-1:0] nbr_row, nbr_col;
    logic          nbr_outside, nbr_exit;
    logic [AW:0]   clr_prev;

    function automatic logic [NW-1:0] size_clamp(input logic [4:0] v);
        logic [NW-1:0] s;
        if (v < 5'd3)
            s = NW'(3);
        else if (32'(v) > GRID_DIM)
            s = NW'(GRID_DIM);
        else
            s = NW'(v);
        return s;
    endfunction

    assign item_stall   = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;
    assign out_free     = !result_valid_reg || !result_stall;

    // Neighbor of the current cell in the current direction
    always_comb
    begin
        drow        = step_drow(cur_dir_reg[2:0]);
        dcol        = step_dcol(cur_dir_reg[2:0]);
        nbr_row     = {1'b0, cur_row_reg} + {{(NW-2){drow[1]}}, drow};
        nbr_col     = {1'b0, cur_col_reg} + {{(NW-2){dcol[1]}}, dcol};
        // a step below zero wraps to all ones, which is beyond any grid size
        nbr_outside = (nbr_row >= rows_reg) || (nbr_col >= cols_reg);
        nbr_exit    = (nbr_row == rows_reg - NW'(2)) && (nbr_col == cols_reg - NW'(2));
        clr_prev    = clr_cnt_reg - (AW+1)'(1);
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        clr_cnt_next   = clr_cnt_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        cur_dir_next   = cur_dir_reg;
        nbr_row_next   = nbr_row_reg;
        nbr_col_next   = nbr_col_reg;
        top_next       = top_reg;
        out_idx_next   = out_idx_reg;
        fail_stat_next = fail_stat_reg;

        cell_rd_en     = 1'b0;
        cell_rd_addr   = {nbr_row[CW-1:0], nbr_col[CW-1:0]};
        cell_wr_en     = 1'b0;
        cell_wr_addr   = {nbr_row_reg, nbr_col_reg};
        cell_wr_data   = '{wall: cell_rdata_reg.wall, seen: 1'b1};
        stack_rd_en    = 1'b0;
        stack_rd_addr  = out_idx_reg[SAW-1:0];
        stack_wr_en    = 1'b0;
        stack_wr_data  = '{row: cur_row_reg, col: cur_col_reg, dir: cur_dir_reg + 4'd1};

        out_load       = 1'b0;
        out_item       = '{path_row: 4'(stack_rdata_reg.row),
                           path_col: 4'(stack_rdata_reg.col),
                           status:   STAT_PATH,
                           last:     1'b0};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (item_data.op == OP_START)
                    begin
                        rows_next    = size_clamp(grid_rows_reg);
                        cols_next    = size_clamp(grid_cols_reg);
                        clr_cnt_next = '0;
                        state_next   = ST_CLEAR;
                    end
                    else if (32'(item_data.cell_row) < GRID_DIM &&
                             32'(item_data.cell_col) < GRID_DIM)
                    begin
                        cell_wr_en   = 1'b1;
                        cell_wr_addr = {CW'(item_data.cell_row), CW'(item_data.cell_col)};
                        cell_wr_data = '{wall: item_data.wall, seen: 1'b0};
                    end
                end
            end

            // Read one entry, write back the previous one with visited cleared;
            // the start cell is marked visited on the way
            ST_CLEAR:
            begin
                if (clr_cnt_reg < (AW+1)'(CELLS))
                begin
                    cell_rd_en   = 1'b1;
                    cell_rd_addr = clr_cnt_reg[AW-1:0];
                end
                if (clr_cnt_reg != '0)
                begin
                    cell_wr_en   = 1'b1;
                    cell_wr_addr = clr_prev[AW-1:0];
                    cell_wr_data = '{wall: cell_rdata_reg.wall,
                                     seen: (clr_prev[AW-1:0] == START_ADDR)};
                end
                clr_cnt_next = clr_cnt_reg + (AW+1)'(1);
                if (clr_cnt_reg == (AW+1)'(CELLS))
                begin
                    cur_row_next = CW'(1);
                    cur_col_next = CW'(1);
                    cur_dir_next = 4'd0;
                    top_next     = '0;
                    state_next   = ST_PROBE;
                end
            end

            // Try this direction's neighbor or the exit; pop or fail when all are done
            ST_PROBE:
            begin
                if (cur_dir_reg[3])
                begin
                    if (top_reg == '0)
                    begin
                        fail_stat_next = STAT_NO_PATH;
                        state_next     = ST_FAIL;
                    end
                    else
                    begin
                        stack_rd_en   = 1'b1;
                        stack_rd_addr = SAW'(top_reg - TW'(1));
                        top_next      = top_reg - TW'(1);
                        state_next    = ST_POP;
                    end
                end
                else if (nbr_exit)
                begin
                    out_idx_next = '0;
                    state_next   = (top_reg == '0) ? ST_OUT_CUR : ST_OUT_RD;
                end
                else if (nbr_outside)
                begin
                    cur_dir_next = cur_dir_reg + 4'd1;
                end
                else
                begin
                    // a write issued last cycle is already in memory for this read
                    cell_rd_en   = 1'b1;
                    nbr_row_next = nbr_row[CW-1:0];
                    nbr_col_next = nbr_col[CW-1:0];
                    state_next   = ST_CHECK;
                end
            end

            // Neighbor word back: push and step, fail when full, or next direction
            ST_CHECK:
            begin
                if (cell_rdata_reg.wall || cell_rdata_reg.seen)
                begin
                    cur_dir_next = cur_dir_reg + 4'd1;
                    state_next   = ST_PROBE;
                end
                else if (top_reg == TW'(STACK_DEPTH))
                begin
                    fail_stat_next = STAT_OVERFLOW;
                    state_next     = ST_FAIL;
                end
                else
                begin
                    cell_wr_en   = 1'b1;
                    stack_wr_en  = 1'b1;
                    top_next     = top_reg + TW'(1);
                    cur_row_next = nbr_row_reg;
                    cur_col_next = nbr_col_reg;
                    cur_dir_next = 4'd0;
                    state_next   = ST_PROBE;
                end
            end

            ST_POP:
            begin
                cur_row_next = stack_rdata_reg.row;
                cur_col_next = stack_rdata_reg.col;
                cur_dir_next = stack_rdata_reg.dir;
                state_next   = ST_PROBE;
            end

            // Stacked cells, bottom to top
            ST_OUT_RD:
            begin
                stack_rd_en = 1'b1;
                state_next  = ST_OUT_LD;
            end

            ST_OUT_LD:
            begin
                if (out_free)
                begin
                    out_load     = 1'b1;
                    out_idx_next = out_idx_reg + TW'(1);
                    state_next   = (out_idx_reg + TW'(1) == top_reg) ? ST_OUT_CUR : ST_OUT_RD;
                end
            end

            ST_OUT_CUR:
            begin
                out_item = '{path_row: 4'(cur_row_reg), path_col: 4'(cur_col_reg),
                             status: STAT_PATH, last: 1'b0};
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_OUT_EXIT;
                end
            end

            ST_OUT_EXIT:
            begin
                out_item = '{path_row: 4'(rows_reg - NW'(2)),
                             path_col: 4'(cols_reg - NW'(2)),
                             status: STAT_PATH, last: 1'b1};
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_FAIL:
            begin
                out_item = '{path_row: 4'd0, path_col: 4'd0,
                             status: fail_stat_reg, last: 1'b1};
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            grid_rows_reg    <= GRID_SIZE_RESET;
            grid_cols_reg    <= GRID_SIZE_RESET;
            result_valid_reg <= 1'b0;
            top_reg          <= '0;
            clr_cnt_reg      <= '0;
            out_idx_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            top_reg     <= top_next;
            clr_cnt_reg <= clr_cnt_next;
            out_idx_reg <= out_idx_next;
            if (cfg_valid && cfg_index == REG_GRID_ROWS)
                grid_rows_reg <= cfg_data;
            if (cfg_valid && cfg_index == REG_GRID_COLS)
                grid_cols_reg <= cfg_data;
            if (out_load)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // Search datapath registers
    always_ff @(posedge clk)
    begin
        rows_reg      <= rows_next;
        cols_reg      <= cols_next;
        cur_row_reg   <= cur_row_next;
        cur_col_reg   <= cur_col_next;
        cur_dir_reg   <= cur_dir_next;
        nbr_row_reg   <= nbr_row_next;
        nbr_col_reg   <= nbr_col_next;
        fail_stat_reg <= fail_stat_next;
        if (out_load)
            result_data_reg <= out_item;
    end

    // Cell memory: one read, one write port, registered read data
    always_ff @(posedge clk)
    begin
        if (cell_wr_en)
            cell_mem[cell_wr_addr] <= cell_wr_data;
        if (cell_rd_en)
            cell_rdata_reg <= cell_mem[cell_rd_addr];
    end

    // Stack memory: read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (stack_wr_en)
            stack_mem[top_reg[SAW-1:0]] <= stack_wr_data;
        if (stack_rd_en)
            stack_rdata_reg <= stack_mem[stack_rd_addr];
    end

endmodule

`default_nettype wire
